@@ hdl/lsee_pkg.sv @@
// Types and constants shared by the LED strip effect engine.
`timescale 1ns / 1ps
package lsee_pkg;

  typedef enum logic [2:0] {
    OP_SET_MODE   = 3'd0,
    OP_SET_COLOUR = 3'd1,
    OP_REFRESH    = 3'd2,
    OP_BLINK_TICK = 3'd3,
    OP_FADE_TICK  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_ON        = 3'd1,
    MODE_BLINK     = 3'd2,
    MODE_BLINK_INV = 3'd3,
    MODE_FADE      = 3'd4,
    MODE_FADE_RG   = 3'd5,
    MODE_FADE_GB   = 3'd6,
    MODE_FADE_BR   = 3'd7
  } mode_e;

  typedef enum logic [0:0] {
    CFG_ZONE_START = 1'b0,
    CFG_ZONE_END   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WRITE = 2'd1,
    ST_SCAN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam int unsigned ZoneW = 5;
  localparam logic [ZoneW-1:0] ZoneStartRst = 5'd15;
  localparam logic [ZoneW-1:0] ZoneEndRst   = 5'd26;
  localparam logic [7:0] FadeStep = 8'd10;
  localparam logic [7:0] FullOn   = 8'hFF;
  localparam rgb_t Black = '{r: 8'h00, g: 8'h00, b: 8'h00};
  localparam rgb_t White = '{r: FullOn, g: FullOn, b: FullOn};
  localparam rgb_t Red   = '{r: FullOn, g: 8'h00, b: 8'h00};

endpackage

@@ hdl/lsee_if.sv @@
// Valid/ready channels for command words and pixel words.
`timescale 1ns / 1ps
interface lsee_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] first_led;
  logic [7:0] middle_bound;
  logic [7:0] end_led;
  logic [2:0] mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (
    output valid, operation, first_led, middle_bound, end_led, mode, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, operation, first_led, middle_bound, end_led, mode, red, green, blue,
    output ready
  );
endinterface

interface lsee_pix_if;
  logic       valid;
  logic       ready;
  logic [4:0] pixel_index;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       last_pixel;

  modport source (
    output valid, pixel_index, pixel_red, pixel_green, pixel_blue, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_index, pixel_red, pixel_green, pixel_blue, last_pixel,
    output ready
  );
endinterface

@@ hdl/led_strip_effect_engine.sv @@
// LED strip effect engine: per-LED mode, colour and shown-colour stores under a scan sequencer.
// A frame pass (refresh, blink or fade tick) reads each LED's stores into stage 1 and
// registers the updated pixel as the output word; a set writes its range [first, end) and
// a dropped command leaves the engine idle. The pace is set by the single read and write
// port of each LED store: one LED per cycle unless the pixel output stalls a scan. Reset sets
// pending, clears blocked and per-LED valid bits, loads zone defaults; no clearing pass is run.
`timescale 1ns / 1ps
module led_strip_effect_engine
  import lsee_pkg::*;
#(
  parameter int unsigned LED_COUNT = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [ZoneW-1:0]       cfg_data_i,
  lsee_cmd_if.sink               cmd_i,
  lsee_pix_if.source             pix_o
);

  // Width of an LED index; never narrower than one bit.
  localparam int unsigned IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(LED_COUNT - 1);
  localparam logic [7:0] LedCnt8 = 8'(LED_COUNT);

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [ZoneW-1:0]  zone_start_q, zone_end_q;
  logic              pending_q, pending_d;
  logic              blocked_q, blocked_d;
  logic [IW-1:0]     idx_q;          // read address in a scan, write address in a set
  logic              rd_more_q;      // scan still has addresses to issue
  logic              s1_valid_q;     // read data for s1_idx_q is present
  logic [IW-1:0]     s1_idx_q;
  logic              out_valid_q;

  // Command held for the duration of a pass
  op_e               op_q;
  mode_e             set_mode_q;
  rgb_t              set_col_q;
  logic [7:0]        end_m1_q;

  // Output word
  logic [4:0]        out_idx_q;
  rgb_t              out_col_q;
  logic              out_last_q;

  // ---------------------------------------------------------------------------
  // Stores: one write and one registered read per cycle each, valid bits for reset values
  // ---------------------------------------------------------------------------
  rgb_t              set_mem   [LED_COUNT];
  rgb_t              shown_mem [LED_COUNT];
  mode_e             mode_mem  [LED_COUNT];
  logic [LED_COUNT-1:0] set_vld_q, shown_vld_q, mode_vld_q;

  rgb_t              set_rd_q, shown_rd_q;
  mode_e             mode_rd_q;
  logic              set_rvld_q, shown_rvld_q, mode_rvld_q;

  // ---------------------------------------------------------------------------
  // Decoded command and handshake terms
  // ---------------------------------------------------------------------------
  op_e               cmd_op;
  logic              cmd_acc;
  logic              range_ok;
  logic              s1_last;
  logic              s1_moves;
  logic              issue;

  assign cmd_op   = op_e'(cmd_i.operation);
  assign cmd_acc  = cmd_i.valid && cmd_i.ready;
  // Reject a range that starts past the strip, has any bound beyond it, or is empty.
  assign range_ok = (cmd_i.first_led < LedCnt8) && (cmd_i.middle_bound <= LedCnt8)
                 && (cmd_i.end_led <= LedCnt8) && (cmd_i.first_led < cmd_i.end_led);
  assign s1_last  = (s1_idx_q == LastIdx);

  // ---------------------------------------------------------------------------
  // Per-LED update: effective (reset-aware) values, then the shared fade adder
  // ---------------------------------------------------------------------------
  mode_e      eff_mode;
  rgb_t       eff_set, eff_shown;
  logic       in_zone;
  logic [7:0] fade_dn, fade_up, fade_dn_res, fade_up_res;
  logic       fade_next;
  mode_e      new_mode;
  rgb_t       new_shown;

  assign eff_mode  = mode_rvld_q  ? mode_rd_q  : MODE_FADE;
  assign eff_set   = set_rvld_q   ? set_rd_q   : Black;
  assign eff_shown = shown_rvld_q ? shown_rd_q : Black;
  assign in_zone   = (8'(s1_idx_q) >= 8'(zone_start_q)) && (8'(s1_idx_q) < 8'(zone_end_q));

  // Pick the falling and rising components for the current fade leg.
  always_comb begin
    case (eff_mode)
      MODE_FADE_RG: begin
        fade_dn = eff_shown.r;
        fade_up = eff_shown.g;
      end
      MODE_FADE_GB: begin
        fade_dn = eff_shown.g;
        fade_up = eff_shown.b;
      end
      default: begin
        fade_dn = eff_shown.b;
        fade_up = eff_shown.r;
      end
    endcase
  end

  // Shared step unit: both wrap at 8 bits.
  assign fade_dn_res = fade_dn - FadeStep;
  assign fade_up_res = fade_up + FadeStep;
  assign fade_next   = (fade_dn_res <= FadeStep);

  always_comb begin
    new_mode  = eff_mode;
    new_shown = eff_shown;
    case (op_q)
      OP_REFRESH: begin
        new_shown = eff_set;
        if (in_zone) begin
          new_mode  = MODE_ON;
          new_shown = White;
        end else if (eff_mode == MODE_OFF) begin
          new_shown = Black;
        end else if (eff_mode == MODE_FADE) begin
          new_mode  = MODE_FADE_RG;
          new_shown = Red;
        end
      end
      OP_BLINK_TICK: begin
        if (eff_mode == MODE_BLINK_INV) begin
          new_shown = Black;
          new_mode  = MODE_BLINK;
        end else if (eff_mode == MODE_BLINK) begin
          new_shown = eff_set;
          new_mode  = MODE_BLINK_INV;
        end
      end
      OP_FADE_TICK: begin
        case (eff_mode)
          MODE_FADE_RG: begin
            new_shown.r = fade_dn_res;
            new_shown.g = fade_up_res;
            if (fade_next) new_mode = MODE_FADE_GB;
          end
          MODE_FADE_GB: begin
            new_shown.g = fade_dn_res;
            new_shown.b = fade_up_res;
            if (fade_next) new_mode = MODE_FADE_BR;
          end
          MODE_FADE_BR: begin
            new_shown.b = fade_dn_res;
            new_shown.r = fade_up_res;
            if (fade_next) new_mode = MODE_FADE_RG;
          end
          default: begin
            new_mode = eff_mode;
          end
        endcase
      end
      default: begin
        new_mode = eff_mode;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          case (cmd_op)
            OP_SET_MODE, OP_SET_COLOUR: begin
              if (range_ok) state_d = ST_WRITE;
            end
            OP_REFRESH: begin
              if (pending_q) state_d = ST_SCAN;
            end
            OP_BLINK_TICK, OP_FADE_TICK: begin
              if (!blocked_q) state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRITE: begin
        if (8'(idx_q) == end_m1_q) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (s1_moves && s1_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (handshake, store ports, flag updates)
  // ---------------------------------------------------------------------------
  logic          mode_we, set_we, shown_we;
  logic [IW-1:0] wr_addr;
  mode_e         mode_wdata;

  always_comb begin
    cmd_i.ready = 1'b0;
    s1_moves    = 1'b0;
    issue       = 1'b0;
    mode_we     = 1'b0;
    set_we      = 1'b0;
    shown_we    = 1'b0;
    wr_addr     = s1_idx_q;
    mode_wdata  = new_mode;
    pending_d   = pending_q;
    blocked_d   = blocked_q;
    case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_acc) begin
          case (cmd_op)
            OP_SET_MODE, OP_SET_COLOUR: begin
              // Block ticks even when the range is rejected.
              blocked_d = 1'b1;
              if (range_ok) pending_d = 1'b1;
            end
            OP_REFRESH: begin
              if (pending_q) begin
                pending_d = 1'b0;
                blocked_d = 1'b0;
              end
            end
            default: begin
              blocked_d = blocked_q;
            end
          endcase
        end
      end
      ST_WRITE: begin
        wr_addr    = idx_q;
        mode_wdata = set_mode_q;
        mode_we    = (op_q == OP_SET_MODE);
        set_we     = (op_q == OP_SET_COLOUR);
      end
      ST_SCAN: begin
        // Stage 1 drains into the output word when that word is free or being taken.
        s1_moves = s1_valid_q && (!out_valid_q || pix_o.ready);
        issue    = rd_more_q && (!s1_valid_q || s1_moves);
        mode_we  = s1_moves;
        shown_we = s1_moves;
      end
      default: begin
        cmd_i.ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      zone_start_q <= ZoneStartRst;
      zone_end_q   <= ZoneEndRst;
      pending_q    <= 1'b1;
      blocked_q    <= 1'b0;
      idx_q        <= '0;
      rd_more_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      set_vld_q    <= '0;
      shown_vld_q  <= '0;
      mode_vld_q   <= '0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      blocked_q <= blocked_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ZONE_START: zone_start_q <= cfg_data_i;
          CFG_ZONE_END:   zone_end_q   <= cfg_data_i;
          default:        zone_start_q <= zone_start_q;
        endcase
      end

      // Address counter: load at the start of a pass, advance per write or read.
      if (state_q == ST_IDLE && state_d == ST_WRITE) begin
        idx_q <= cmd_i.first_led[IW-1:0];
      end else if (state_q == ST_IDLE && state_d == ST_SCAN) begin
        idx_q     <= '0;
        rd_more_q <= 1'b1;
      end else if (state_q == ST_WRITE) begin
        idx_q <= idx_q + IW'(1);
      end else if (issue) begin
        idx_q     <= idx_q + IW'(1);
        rd_more_q <= (idx_q != LastIdx);
      end

      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_moves) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_moves) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (mode_we)  mode_vld_q[wr_addr]  <= 1'b1;
      if (set_we)   set_vld_q[wr_addr]   <= 1'b1;
      if (shown_we) shown_vld_q[wr_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      op_q       <= cmd_op;
      set_mode_q <= mode_e'(cmd_i.mode);
      set_col_q  <= '{r: cmd_i.red, g: cmd_i.green, b: cmd_i.blue};
      end_m1_q   <= cmd_i.end_led - 8'd1;
    end
    if (issue) begin
      s1_idx_q     <= idx_q;
      set_rvld_q   <= set_vld_q[idx_q];
      shown_rvld_q <= shown_vld_q[idx_q];
      mode_rvld_q  <= mode_vld_q[idx_q];
    end
    if (s1_moves) begin
      out_idx_q  <= 5'(s1_idx_q);
      out_col_q  <= new_shown;
      out_last_q <= s1_last;
    end
  end

  // Store arrays
  always_ff @(posedge clk_i) begin
    if (mode_we) mode_mem[wr_addr] <= mode_wdata;
    if (issue)   mode_rd_q <= mode_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (set_we) set_mem[wr_addr] <= set_col_q;
    if (issue)  set_rd_q <= set_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (shown_we) shown_mem[wr_addr] <= new_shown;
    if (issue)    shown_rd_q <= shown_mem[idx_q];
  end

  // ---------------------------------------------------------------------------
  // Pixel word out
  // ---------------------------------------------------------------------------
  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_index = out_idx_q;
  assign pix_o.pixel_red   = out_col_q.r;
  assign pix_o.pixel_green = out_col_q.g;
  assign pix_o.pixel_blue  = out_col_q.b;
  assign pix_o.last_pixel  = out_last_q;

`ifndef SYNTH
  // A set pass never runs past the end of its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (8'(idx_q) <= end_m1_q))
    else $error("set pass ran past its range");

  // Read data only exists while a frame pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (state_q == ST_SCAN))
    else $error("stage data outside a frame pass");

  // Any accepted set command blocks ticks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (cmd_op == OP_SET_MODE || cmd_op == OP_SET_COLOUR)) |=> blocked_q)
    else $error("set command did not raise the block flag");

  // A refresh with pending settings starts a frame pass and clears the flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && cmd_op == OP_REFRESH && pending_q)
      |=> (state_q == ST_SCAN && !pending_q && !blocked_q))
    else $error("refresh did not start a frame pass");
`endif

endmodule
